[src/pcs_pkg.sv]
// ----------------------------------------------------------------------------
// pcs_pkg
// Types, constants and the palette table shared by the color shift pipeline.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int MAX_SLOTS     = 16;
    localparam int SLOT_W        = 4;
    localparam int DIST_W        = 18;
    localparam int SCALED_W      = 31;
    localparam int LIM_W         = 32;
    localparam int PP_W          = 14;
    localparam int QUO_W         = 32;
    localparam int ROOT_STEPS    = 16;
    localparam int FRAC_W        = 16;
    localparam int PROD_W        = 24;
    localparam int PERCENT_W     = 7;

    localparam logic [17:0] FULL_RANGE_SQ = 18'd195075;
    localparam logic [13:0] DIST_SCALE    = 14'd10000;
    localparam logic [23:0] ROUND_HALF    = 24'd32768;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [2:0] nearest_index;
    } t_pix_out;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_SNAP,
        MODE_MOVE
    } t_mode;

    // Per-transaction data that rides along with the arithmetic
    typedef struct packed {
        t_pix_in           pix;
        logic [SLOT_W-1:0] idx;
        t_mode             mode;
    } t_side;

    // Palette color as {red, green, blue}
    function automatic logic [23:0] pal_rgb(input logic [SLOT_W-1:0] idx);
        logic [23:0] c;
        case (idx)
            4'd1:    c = {8'd20,  8'd245, 8'd60};
            4'd2:    c = {8'd255, 8'd68,  8'd253};
            4'd3:    c = {8'd255, 8'd255, 8'd255};
            4'd5:    c = {8'd255, 8'd106, 8'd60};
            4'd6:    c = {8'd20,  8'd207, 8'd253};
            4'd7:    c = {8'd255, 8'd255, 8'd255};
            default: c = 24'd0;
        endcase
        return c;
    endfunction

endpackage

[src/pcs_nearest.sv]
// ----------------------------------------------------------------------------
// pcs_nearest
// Palette distance, nearest-color search and limit comparison (3 stages).
// ----------------------------------------------------------------------------
module pcs_nearest
    import pcs_pkg::*;
#(
    parameter int PALETTE_SIZE = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_pix_in              i_pix,
    input  logic [PERCENT_W-1:0] i_percent,
    input  logic [LIM_W-1:0]     i_lim,
    output logic                 o_valid,
    output t_side                o_side,
    output logic [SCALED_W-1:0]  o_scaled,
    output logic [LIM_W-1:0]     o_lim
);

    logic                r_v1;
    t_pix_in             r_pix1;
    logic [DIST_W-1:0]   r_dist1 [MAX_SLOTS];

    logic                r_v2;
    t_pix_in             r_pix2;
    logic [SLOT_W-1:0]   r_idx2;
    logic [DIST_W-1:0]   r_dist2;

    logic [DIST_W-1:0]   ld [MAX_SLOTS];
    logic [SLOT_W-1:0]   li [MAX_SLOTS];
    logic [DIST_W-1:0]   n_dist1 [MAX_SLOTS];
    logic [SCALED_W-1:0] n_scaled;
    t_mode               n_mode;

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    genvar g;
    generate
        for (g = 0; g < MAX_SLOTS; g++) begin : g_dist
            if (g < PALETTE_SIZE) begin : g_used
                logic [23:0] pc;
                assign pc = pal_rgb(SLOT_W'(g));
                assign n_dist1[g] = DIST_W'(sq_diff(i_pix.red_in, pc[23:16]))
                                  + DIST_W'(sq_diff(i_pix.green_in, pc[15:8]))
                                  + DIST_W'(sq_diff(i_pix.blue_in, pc[7:0]));
            end else begin : g_unused
                // Larger than any real distance: never wins
                assign n_dist1[g] = '1;
            end
        end
    endgenerate

    // Pairwise tree, lower index wins ties
    always_comb begin
        for (int k = 0; k < MAX_SLOTS; k++) begin
            ld[k] = r_dist1[k];
            li[k] = SLOT_W'(k);
        end
        for (int lev = 0; lev < SLOT_W; lev++) begin
            for (int k = 0; k < (MAX_SLOTS >> (lev + 1)); k++) begin
                if (ld[2*k] <= ld[2*k+1]) begin
                    ld[k] = ld[2*k];
                    li[k] = li[2*k];
                end else begin
                    ld[k] = ld[2*k+1];
                    li[k] = li[2*k+1];
                end
            end
        end
    end

    always_comb begin
        n_scaled = SCALED_W'(r_dist2) * SCALED_W'(DIST_SCALE);
        if (i_percent == '0) begin
            n_mode = MODE_PASS;
        end else if ({1'b0, n_scaled} <= i_lim) begin
            n_mode = MODE_SNAP;
        end else begin
            n_mode = MODE_MOVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            o_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix1      <= i_pix;
            r_dist1     <= n_dist1;
            r_pix2      <= r_pix1;
            r_idx2      <= li[0];
            r_dist2     <= ld[0];
            o_side.pix  <= r_pix2;
            o_side.idx  <= r_idx2;
            o_side.mode <= n_mode;
            o_scaled    <= n_scaled;
            o_lim       <= i_lim;
        end
    end

endmodule

[src/pcs_divider.sv]
// ----------------------------------------------------------------------------
// pcs_divider
// Restoring divider, one quotient bit per stage: floor(lim * 2^32 / scaled).
// ----------------------------------------------------------------------------
module pcs_divider
    import pcs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_side               i_side,
    input  logic [LIM_W-1:0]    i_rem,
    input  logic [SCALED_W-1:0] i_div,
    output logic                o_valid,
    output t_side               o_side,
    output logic [QUO_W-1:0]    o_quo
);

    logic                r_v   [QUO_W];
    t_side               r_sd  [QUO_W];
    logic [LIM_W-1:0]    r_rem [QUO_W];
    logic [SCALED_W-1:0] r_div [QUO_W];
    logic [QUO_W-1:0]    r_quo [QUO_W];

    logic                s_v   [QUO_W+1];
    t_side               s_sd  [QUO_W+1];
    logic [LIM_W-1:0]    s_rem [QUO_W+1];
    logic [SCALED_W-1:0] s_div [QUO_W+1];
    logic [QUO_W-1:0]    s_quo [QUO_W+1];

    assign s_v[0]   = i_valid;
    assign s_sd[0]  = i_side;
    assign s_rem[0] = i_rem;
    assign s_div[0] = i_div;
    assign s_quo[0] = '0;

    genvar g;
    generate
        for (g = 0; g < QUO_W; g++) begin : g_stage
            logic [LIM_W:0] sh;
            logic           ge;
            logic [LIM_W:0] diff;
            assign sh   = {s_rem[g], 1'b0};
            assign ge   = sh >= (LIM_W+1)'(s_div[g]);
            assign diff = sh - (LIM_W+1)'(s_div[g]);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= s_v[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sd[g]  <= s_sd[g];
                    r_div[g] <= s_div[g];
                    r_rem[g] <= ge ? diff[LIM_W-1:0] : sh[LIM_W-1:0];
                    r_quo[g] <= {s_quo[g][QUO_W-2:0], ge};
                end
            end

            assign s_v[g+1]   = r_v[g];
            assign s_sd[g+1]  = r_sd[g];
            assign s_rem[g+1] = r_rem[g];
            assign s_div[g+1] = r_div[g];
            assign s_quo[g+1] = r_quo[g];
        end
    endgenerate

    assign o_valid = s_v[QUO_W];
    assign o_side  = s_sd[QUO_W];
    assign o_quo   = s_quo[QUO_W];

endmodule

[src/pcs_isqrt.sv]
// ----------------------------------------------------------------------------
// pcs_isqrt
// Integer square root of a 32-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module pcs_isqrt
    import pcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [QUO_W-1:0]  i_val,
    output logic              o_valid,
    output t_side             o_side,
    output logic [FRAC_W-1:0] o_root
);

    logic             r_v   [ROOT_STEPS];
    t_side            r_sd  [ROOT_STEPS];
    logic [QUO_W-1:0] r_val [ROOT_STEPS];
    logic [QUO_W-1:0] r_res [ROOT_STEPS];

    logic             s_v   [ROOT_STEPS+1];
    t_side            s_sd  [ROOT_STEPS+1];
    logic [QUO_W-1:0] s_val [ROOT_STEPS+1];
    logic [QUO_W-1:0] s_res [ROOT_STEPS+1];

    assign s_v[0]   = i_valid;
    assign s_sd[0]  = i_side;
    assign s_val[0] = i_val;
    assign s_res[0] = '0;

    genvar g;
    generate
        for (g = 0; g < ROOT_STEPS; g++) begin : g_stage
            localparam logic [QUO_W-1:0] BIT = QUO_W'(1) << (QUO_W - 2 - 2*g);
            logic [QUO_W:0] trial;
            logic           ge;
            assign trial = {1'b0, s_res[g]} + {1'b0, BIT};
            assign ge    = {1'b0, s_val[g]} >= trial;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= s_v[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sd[g]  <= s_sd[g];
                    r_val[g] <= ge ? (s_val[g] - trial[QUO_W-1:0]) : s_val[g];
                    r_res[g] <= ge ? ((s_res[g] >> 1) + BIT) : (s_res[g] >> 1);
                end
            end

            assign s_v[g+1]   = r_v[g];
            assign s_sd[g+1]  = r_sd[g];
            assign s_val[g+1] = r_val[g];
            assign s_res[g+1] = r_res[g];
        end
    endgenerate

    assign o_valid = s_v[ROOT_STEPS];
    assign o_side  = s_sd[ROOT_STEPS];
    assign o_root  = s_res[ROOT_STEPS][FRAC_W-1:0];

endmodule

[src/pcs_blend.sv]
// ----------------------------------------------------------------------------
// pcs_blend
// Scales each channel's step toward the palette color and picks the result.
// ----------------------------------------------------------------------------
module pcs_blend
    import pcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [FRAC_W-1:0] i_factor,
    output logic              o_valid,
    output t_pix_out          o_pix
);

    logic              r_v;
    t_side             r_sd;
    logic [PROD_W-1:0] r_prod [3];
    logic [2:0]        r_up;

    logic [7:0]        c_in   [3];
    logic [7:0]        t_in   [3];
    logic [7:0]        c_r    [3];
    logic [7:0]        t_r    [3];
    logic [PROD_W-1:0] n_prod [3];
    logic [2:0]        n_up;
    logic [7:0]        moved  [3];
    logic [7:0]        sel    [3];
    logic [23:0]       pal_in;
    logic [23:0]       pal_r;
    logic [PROD_W-1:0] rnd;

    assign pal_in = pal_rgb(i_side.idx);
    assign pal_r  = pal_rgb(r_sd.idx);

    always_comb begin
        c_in[0] = i_side.pix.red_in;
        c_in[1] = i_side.pix.green_in;
        c_in[2] = i_side.pix.blue_in;
        t_in[0] = pal_in[23:16];
        t_in[1] = pal_in[15:8];
        t_in[2] = pal_in[7:0];
        c_r[0]  = r_sd.pix.red_in;
        c_r[1]  = r_sd.pix.green_in;
        c_r[2]  = r_sd.pix.blue_in;
        t_r[0]  = pal_r[23:16];
        t_r[1]  = pal_r[15:8];
        t_r[2]  = pal_r[7:0];
        rnd     = '0;
        for (int k = 0; k < 3; k++) begin
            n_up[k]   = t_in[k] >= c_in[k];
            n_prod[k] = (n_up[k] ? (t_in[k] - c_in[k]) : (c_in[k] - t_in[k])) * i_factor;
        end
        for (int k = 0; k < 3; k++) begin
            rnd      = (r_prod[k] + ROUND_HALF) >> FRAC_W;
            moved[k] = r_up[k] ? (c_r[k] + rnd[7:0]) : (c_r[k] - rnd[7:0]);
            case (r_sd.mode)
                MODE_PASS: sel[k] = c_r[k];
                MODE_SNAP: sel[k] = t_r[k];
                MODE_MOVE: sel[k] = moved[k];
                default:   sel[k] = c_r[k];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v     <= i_valid;
            o_valid <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd                <= i_side;
            r_prod              <= n_prod;
            r_up                <= n_up;
            o_pix.red_out       <= sel[0];
            o_pix.green_out     <= sel[1];
            o_pix.blue_out      <= sel[2];
            o_pix.nearest_index <= r_sd.idx[2:0];
        end
    end

endmodule

[src/palette_color_shift.sv]
// ----------------------------------------------------------------------------
// palette_color_shift
// Pulls each RGB pixel toward the nearest of eight palette colors.
// ----------------------------------------------------------------------------
// One pixel per clock is taken and one result per clock is delivered while the
// output does not stall. The pipeline is the 32-stage restoring divider and the
// 16-stage square root that form the step factor, plus three search stages, two
// blend stages and the output register. A skid register behind the pipeline
// absorbs one result when the output stalls, so the input stalls only once that
// register is full. The percent register feeds a limit computation, registered
// in r_pp and then r_lim, that runs freely.
// ----------------------------------------------------------------------------
module palette_color_shift
    import pcs_pkg::*;
#(
    parameter int PALETTE_SIZE = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [PERCENT_W-1:0] i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_pix_in              i_pix,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_pix_out             o_pix
);

    logic [PERCENT_W-1:0] r_shift_percent;
    logic [PP_W-1:0]      r_pp;
    logic [LIM_W-1:0]     r_lim;

    logic                 en;
    logic                 n_valid;
    t_side                n_side;
    logic [SCALED_W-1:0]  n_scaled;
    logic [LIM_W-1:0]     n_lim;
    logic                 d_valid;
    t_side                d_side;
    logic [QUO_W-1:0]     d_quo;
    logic                 q_valid;
    t_side                q_side;
    logic [FRAC_W-1:0]    q_root;
    logic                 b_valid;
    t_pix_out             b_pix;
    logic                 tail_take;

    logic                 r_skid_valid;
    t_pix_out             r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_percent <= '0;
        end else if (i_cfg_wr_en) begin
            r_shift_percent <= i_cfg_wr_data;
        end
    end

    // Squared percent times FULL_RANGE_SQ (195075), split over two multiplies
    always_ff @(posedge i_clk) begin
        r_pp  <= r_shift_percent * r_shift_percent;
        r_lim <= LIM_W'(FULL_RANGE_SQ) * LIM_W'(r_pp);
    end

    assign en        = !r_skid_valid;
    assign o_stall   = r_skid_valid;
    assign tail_take = b_valid && en;

    pcs_nearest #(
        .PALETTE_SIZE(PALETTE_SIZE)
    ) u_nearest (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_pix     (i_pix),
        .i_percent (r_shift_percent),
        .i_lim     (r_lim),
        .o_valid   (n_valid),
        .o_side    (n_side),
        .o_scaled  (n_scaled),
        .o_lim     (n_lim)
    );

    pcs_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (n_valid),
        .i_side  (n_side),
        .i_rem   (n_lim),
        .i_div   (n_scaled),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_quo   (d_quo)
    );

    pcs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_side  (d_side),
        .i_val   (d_quo),
        .o_valid (q_valid),
        .o_side  (q_side),
        .o_root  (q_root)
    );

    pcs_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (q_valid),
        .i_side   (q_side),
        .i_factor (q_root),
        .o_valid  (b_valid),
        .o_pix    (b_pix)
    );

    // Output register with one-deep skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!o_valid || !i_stall) begin
            if (r_skid_valid) begin
                o_valid      <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                o_valid <= tail_take;
            end
        end else if (tail_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_valid || !i_stall) begin
            o_pix <= r_skid_valid ? r_skid : b_pix;
        end else if (tail_take) begin
            // hold the pending transaction until the output frees up
            r_skid <= b_pix;
        end
    end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Streams pixels through palette_color_shift under random idle and stall,
// predicts each shifted pixel and nearest index, and checks results in order.
// ----------------------------------------------------------------------------
module tb_top
    import pcs_pkg::*;
;

    localparam int LATENCY   = 54;
    localparam int MAX_CYCLE = 2000000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [PERCENT_W-1:0] i_cfg_wr_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_pix_in              i_pix = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_pix_out             o_pix;

    palette_color_shift u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pix         (i_pix),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pix         (o_pix)
    );

    always #5 i_clk = ~i_clk;

    t_pix_in    pending_pix[$];
    t_pix_out   expected_pix[$];
    logic [6:0] shift_pct;
    int         errors = 0;
    int         cycle = 0;
    int         gap = 0;
    int         hold = 0;

    function automatic logic [23:0] palette_color(input int idx);
        case (idx)
            1:       return {8'd20,  8'd245, 8'd60};
            2:       return {8'd255, 8'd68,  8'd253};
            3, 7:    return {8'd255, 8'd255, 8'd255};
            5:       return {8'd255, 8'd106, 8'd60};
            6:       return {8'd20,  8'd207, 8'd253};
            default: return 24'd0;
        endcase
    endfunction

    function automatic logic [31:0] int_sqrt(input logic [31:0] v);
        logic [31:0] r;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            if (64'(r | (32'd1 << b)) * 64'(r | (32'd1 << b)) <= 64'(v))
                r = r | (32'd1 << b);
        end
        return r;
    endfunction

    function automatic t_pix_out shift_pixel(input t_pix_in px, input logic [6:0] pct);
        int          c[3];
        int          best;
        int          best_dist;
        int          dsq;
        int          d;
        logic [23:0] pc;
        logic [63:0] lim;
        logic [63:0] scaled;
        logic [31:0] f;
        logic [63:0] m;
        t_pix_out    r;
        c[0] = int'(px.red_in); c[1] = int'(px.green_in); c[2] = int'(px.blue_in);
        best = 0;
        best_dist = 32'h7fffffff;
        for (int i = 0; i < 8; i++) begin
            pc = palette_color(i);
            dsq = 0;
            for (int k = 0; k < 3; k++) begin
                d = c[k] - int'(pc[23-8*k -: 8]);
                dsq += d * d;
            end
            if (dsq < best_dist) begin
                best_dist = dsq;
                best = i;
            end
        end
        pc = palette_color(best);
        if (pct != 0) begin
            lim = 64'd195075 * pct * pct;
            scaled = 64'(best_dist) * 64'd10000;
            if (scaled <= lim) begin
                for (int k = 0; k < 3; k++) c[k] = int'(pc[23-8*k -: 8]);
            end else begin
                f = int_sqrt(32'((lim << 32) / scaled));
                for (int k = 0; k < 3; k++) begin
                    d = int'(pc[23-8*k -: 8]) - c[k];
                    m = ((d < 0 ? -d : d) * 64'(f) + 64'd32768) >> 16;
                    c[k] = d < 0 ? c[k] - int'(m) : c[k] + int'(m);
                end
            end
        end
        r.red_out = 8'(c[0]); r.green_out = 8'(c[1]); r.blue_out = 8'(c[2]);
        r.nearest_index = 3'(best);
        return r;
    endfunction

    function automatic int draw_gap();
        if ($urandom_range(0, 99) < 40) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Driver: present pixels from the pending queue; hold while stalled
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_pix.push_back(shift_pixel(i_pix, shift_pct));
                void'(pending_pix.pop_front());
                gap = draw_gap();
            end
            if (!i_valid || !o_stall) begin
                if (gap > 0) begin
                    gap--;
                    i_valid <= 1'b0;
                end else if (pending_pix.size() > 0) begin
                    i_valid <= 1'b1;
                    i_pix   <= pending_pix[0];
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_pix_out exp_px;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_pix.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_pix);
                    errors++;
                end else begin
                    exp_px = expected_pix.pop_front();
                    if (exp_px !== o_pix) begin
                        $display("%0t: mismatch expected %h actual %h", $time, exp_px, o_pix);
                        errors++;
                    end
                end
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else begin
                hold = draw_gap();
                i_stall <= hold > 0;
            end
        end
        if (cycle > MAX_CYCLE) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic drain();
        while (pending_pix.size() > 0 || i_valid || expected_pix.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_percent(input logic [6:0] pct);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= pct;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shift_pct = pct;
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_pix_in rand_pixel();
        t_pix_in p;
        logic [23:0] pc;
        p = 24'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            // land near a palette color to exercise the snap case
            pc = palette_color($urandom_range(0, 7));
            p.red_in   = 8'(int'(pc[23:16]) + $urandom_range(0, 12) - 6);
            p.green_in = 8'(int'(pc[15:8])  + $urandom_range(0, 12) - 6);
            p.blue_in  = 8'(int'(pc[7:0])   + $urandom_range(0, 12) - 6);
        end
        return p;
    endfunction

    initial begin
        logic [6:0] pcts[8];
        shift_pct = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, palette colors, ties, pass-through at reset value
        pending_pix.push_back('0);
        pending_pix.push_back('1);
        pending_pix.push_back({8'd255, 8'd0, 8'd0});
        pending_pix.push_back({8'd0, 8'd255, 8'd0});
        pending_pix.push_back({8'd0, 8'd0, 8'd255});
        pending_pix.push_back({8'd128, 8'd128, 8'd128});
        for (int i = 1; i < 8; i++) pending_pix.push_back(palette_color(i));
        drain();
        pcts = '{7'd100, 7'd1, 7'd127, 7'd50, 7'd0, 7'd10, 7'd101, 7'd30};
        foreach (pcts[j]) begin
            write_percent(pcts[j]);
            pending_pix.push_back('0);
            pending_pix.push_back('1);
            pending_pix.push_back({8'd10, 8'd200, 8'd100});
            for (int i = 0; i < 160; i++) pending_pix.push_back(rand_pixel());
            drain();
        end
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
